/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. All checks are sampled on the rising
// edge of clk and are switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

/* rtl/cia_tmr_pkg.sv */
package cia_tmr_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] reg_index;
    logic [7:0] write_data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
  } out_t;

  // Register map.
  localparam logic [3:0] REG_TA_LO = 4'd4;
  localparam logic [3:0] REG_TA_HI = 4'd5;
  localparam logic [3:0] REG_TB_LO = 4'd6;
  localparam logic [3:0] REG_TB_HI = 4'd7;
  localparam logic [3:0] REG_ICR   = 4'd13;
  localparam logic [3:0] REG_CRA   = 4'd14;
  localparam logic [3:0] REG_CRB   = 4'd15;

  // Control register bits.
  localparam int CR_START   = 0;
  localparam int CR_ONESHOT = 3;
  localparam int CR_LOAD    = 4;
  localparam int CR_CASCADE = 5;
  localparam logic [7:0] CR_STORE_MASK = 8'hef;

  // Interrupt control register.
  localparam int ICR_IR      = 7;
  localparam int ICR_SETCLR  = 7;
  localparam int MASK_TA     = 0;
  localparam int MASK_TB     = 1;
  localparam logic [7:0] ICR_FLAG_TA = 8'h81;
  localparam logic [7:0] ICR_FLAG_TB = 8'h82;

endpackage

/* rtl/cia_dual_timer_interrupt_top.sv */
// Two 16-bit CIA-style interval timers with an interrupt control register.
// Every input beat (tick, register read or register write) yields exactly one
// result beat carrying the read byte and the interrupt line level after that
// beat. The register state is updated at the edge that accepts a beat and
// the output register takes the result at that same edge, so the block
// sustains one beat per clock; the rate is set by the combinational
// next-state logic of the counters and register file. A held output stalls
// the input only while the output register is full and stalled.
module cia_dual_timer_interrupt_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cia_tmr_pkg::in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cia_tmr_pkg::out_t  out_data
);
  import cia_tmr_pkg::*;

  `include "assert_macros.svh"

  logic out_valid_r;
  out_t out_data_r;
  out_t res;
  logic take;

  assign in_stall  = out_valid_r && out_stall;
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cia_tmr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  `ASSERT_CLK(a_full_stalls_input, (out_valid && out_stall) |-> in_stall,
              "input not stalled while output register is held")
  `ASSERT_CLK(a_beat_gives_result, take |=> out_valid,
              "accepted beat produced no result")
  `ASSERT_CLK(a_icr_read_drops_irq,
              (take && (in_data.cmd == CMD_READ) && (in_data.reg_index == REG_ICR))
                |=> !out_data.irq_line,
              "interrupt line still high after reading the interrupt register")

endmodule

/* rtl/cia_tmr_core.sv */
module cia_tmr_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  cia_tmr_pkg::in_t   item,
  output cia_tmr_pkg::out_t  res
);
  import cia_tmr_pkg::*;

  logic [7:0]  gen_r [16];
  logic [15:0] cnt_a_r, cnt_a_nxt;
  logic [15:0] cnt_b_r, cnt_b_nxt;
  logic [15:0] latch_a_r, latch_a_nxt;
  logic [15:0] latch_b_r, latch_b_nxt;
  logic [7:0]  icr_r, icr_nxt;
  logic [7:0]  cra_r, cra_nxt;
  logic [7:0]  crb_r, crb_nxt;
  logic [4:0]  mask_r, mask_nxt;
  logic        irq_r, irq_nxt;
  logic        gen_wr;
  logic [15:0] a_dec, b_cur, b_dec;
  logic [7:0]  rd_mux, rd;

  always_comb begin
    case (item.reg_index)
      REG_TA_LO: rd_mux = cnt_a_r[7:0];
      REG_TA_HI: rd_mux = cnt_a_r[15:8];
      REG_TB_LO: rd_mux = cnt_b_r[7:0];
      REG_TB_HI: rd_mux = cnt_b_r[15:8];
      REG_ICR:   rd_mux = icr_r;
      REG_CRA:   rd_mux = cra_r;
      REG_CRB:   rd_mux = crb_r;
      default:   rd_mux = gen_r[item.reg_index];
    endcase
  end

  always_comb begin
    cnt_a_nxt   = cnt_a_r;
    cnt_b_nxt   = cnt_b_r;
    latch_a_nxt = latch_a_r;
    latch_b_nxt = latch_b_r;
    icr_nxt     = icr_r;
    cra_nxt     = cra_r;
    crb_nxt     = crb_r;
    mask_nxt    = mask_r;
    irq_nxt     = irq_r;
    gen_wr      = 1'b0;
    rd          = 8'h00;
    a_dec       = cnt_a_r - 16'd1;
    b_cur       = cnt_b_r;
    b_dec       = 16'd0;

    case (item.cmd)
      CMD_TICK: begin
        if (cra_r[CR_START] && (cnt_a_r != 16'd0)) begin
          if (a_dec != 16'd0) begin
            cnt_a_nxt = a_dec;
          end else begin
            // Underflow of A may pull B down once before B's own tick.
            if (crb_r[CR_CASCADE] && (cnt_b_r != 16'd0)) begin
              b_cur = cnt_b_r - 16'd1;
            end
            if (mask_r[MASK_TA]) begin
              icr_nxt = icr_nxt | ICR_FLAG_TA;
              irq_nxt = 1'b1;
              if (cra_r[CR_ONESHOT]) begin
                cra_nxt[CR_START] = 1'b0;
              end
            end
            cnt_a_nxt = latch_a_r;
          end
        end
        cnt_b_nxt = b_cur;
        if (crb_r[CR_START] && (b_cur != 16'd0)) begin
          b_dec = b_cur - 16'd1;
          if (b_dec != 16'd0) begin
            cnt_b_nxt = b_dec;
          end else begin
            if (mask_r[MASK_TB]) begin
              icr_nxt = icr_nxt | ICR_FLAG_TB;
              irq_nxt = 1'b1;
              if (crb_r[CR_ONESHOT]) begin
                crb_nxt[CR_START] = 1'b0;
              end
            end
            cnt_b_nxt = latch_b_r;
          end
        end
      end
      CMD_READ: begin
        rd = rd_mux;
        if (item.reg_index == REG_ICR) begin
          if (icr_r[ICR_IR]) begin
            irq_nxt = 1'b0;
          end
          icr_nxt = 8'h00;
        end
      end
      CMD_WRITE: begin
        case (item.reg_index)
          REG_ICR: begin
            if (item.write_data[ICR_SETCLR]) begin
              mask_nxt = mask_r | item.write_data[4:0];
            end else begin
              mask_nxt = mask_r & ~item.write_data[4:0];
            end
          end
          REG_TA_LO: latch_a_nxt[7:0] = item.write_data;
          REG_TB_LO: latch_b_nxt[7:0] = item.write_data;
          REG_TA_HI: begin
            latch_a_nxt[15:8] = item.write_data;
            if (!cra_r[CR_START]) begin
              cnt_a_nxt = {item.write_data, latch_a_r[7:0]};
            end
          end
          REG_TB_HI: begin
            latch_b_nxt[15:8] = item.write_data;
            if (!crb_r[CR_START]) begin
              cnt_b_nxt = {item.write_data, latch_b_r[7:0]};
            end
          end
          REG_CRA: begin
            if (item.write_data[CR_LOAD]) begin
              cnt_a_nxt = latch_a_r;
            end
            cra_nxt = item.write_data & CR_STORE_MASK;
          end
          REG_CRB: begin
            if (item.write_data[CR_LOAD]) begin
              cnt_b_nxt = latch_b_r;
            end
            crb_nxt = item.write_data & CR_STORE_MASK;
          end
          default: gen_wr = 1'b1;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign res.read_data = rd;
  assign res.irq_line  = irq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        gen_r[i] <= 8'h00;
      end
      cnt_a_r   <= 16'd0;
      cnt_b_r   <= 16'd0;
      latch_a_r <= 16'd0;
      latch_b_r <= 16'd0;
      icr_r     <= 8'h00;
      cra_r     <= 8'h00;
      crb_r     <= 8'h00;
      mask_r    <= 5'd0;
      irq_r     <= 1'b0;
    end else if (take) begin
      if (gen_wr) begin
        gen_r[item.reg_index] <= item.write_data;
      end
      cnt_a_r   <= cnt_a_nxt;
      cnt_b_r   <= cnt_b_nxt;
      latch_a_r <= latch_a_nxt;
      latch_b_r <= latch_b_nxt;
      icr_r     <= icr_nxt;
      cra_r     <= cra_nxt;
      crb_r     <= crb_nxt;
      mask_r    <= mask_nxt;
      irq_r     <= irq_nxt;
    end
  end

endmodule

/* sim/cia_dual_timer_interrupt_top_tb.sv */
module cia_dual_timer_interrupt_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cia_tmr_pkg::*;

  // The command code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Shadow copy of the timer block, advanced once per accepted beat.
  logic [7:0]  shadow_regs [16];
  logic [15:0] reload_a;
  logic [15:0] reload_b;
  logic [4:0]  irq_enables;
  logic        irq_out;

  out_t pending_results [$];
  int   mismatch_count = 0;
  int   sent_count = 0;
  int   cycle_count = 0;
  bit   idling_on = 1'b1;

  cia_dual_timer_interrupt_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void reset_model();
    for (int i = 0; i < 16; i++) shadow_regs[i] = 8'h00;
    reload_a    = 16'h0000;
    reload_b    = 16'h0000;
    irq_enables = 5'h00;
    irq_out     = 1'b0;
  endfunction

  function automatic logic [15:0] counter_value(logic [3:0] lo);
    return {shadow_regs[lo + 4'd1], shadow_regs[lo]};
  endfunction

  function automatic void load_counter(logic [3:0] lo, logic [15:0] value);
    shadow_regs[lo]        = value[7:0];
    shadow_regs[lo + 4'd1] = value[15:8];
  endfunction

  function automatic void count_down(bit timer_b);
    logic [3:0]  lo;
    logic [3:0]  ctrl;
    logic [15:0] cnt;
    logic [15:0] chained;
    lo   = timer_b ? REG_TB_LO : REG_TA_LO;
    ctrl = timer_b ? REG_CRB : REG_CRA;
    cnt  = counter_value(lo);
    if (cnt == 16'd0 || !shadow_regs[ctrl][CR_START]) return;
    cnt = cnt - 16'd1;
    load_counter(lo, cnt);
    if (cnt != 16'd0) return;
    // Timer A running out pulls timer B down by one, but never flags for B.
    if (!timer_b && shadow_regs[REG_CRB][CR_CASCADE]) begin
      chained = counter_value(REG_TB_LO);
      if (chained != 16'd0) load_counter(REG_TB_LO, chained - 16'd1);
    end
    if (irq_enables[timer_b ? MASK_TB : MASK_TA]) begin
      shadow_regs[REG_ICR] |= timer_b ? ICR_FLAG_TB : ICR_FLAG_TA;
      irq_out = 1'b1;
      if (shadow_regs[ctrl][CR_ONESHOT]) shadow_regs[ctrl][CR_START] = 1'b0;
    end
    load_counter(lo, timer_b ? reload_b : reload_a);
  endfunction

  function automatic void write_register(logic [3:0] idx, logic [7:0] value);
    case (idx)
      REG_ICR: begin
        if (value[ICR_SETCLR]) irq_enables = irq_enables | value[4:0];
        else irq_enables = irq_enables & ~value[4:0];
      end
      REG_TA_LO: reload_a[7:0] = value;
      REG_TB_LO: reload_b[7:0] = value;
      REG_TA_HI: begin
        reload_a[15:8] = value;
        if (!shadow_regs[REG_CRA][CR_START]) load_counter(REG_TA_LO, reload_a);
      end
      REG_TB_HI: begin
        reload_b[15:8] = value;
        if (!shadow_regs[REG_CRB][CR_START]) load_counter(REG_TB_LO, reload_b);
      end
      REG_CRA: begin
        if (value[CR_LOAD]) load_counter(REG_TA_LO, reload_a);
        shadow_regs[REG_CRA] = value & CR_STORE_MASK;
      end
      REG_CRB: begin
        if (value[CR_LOAD]) load_counter(REG_TB_LO, reload_b);
        shadow_regs[REG_CRB] = value & CR_STORE_MASK;
      end
      default: shadow_regs[idx] = value;
    endcase
  endfunction

  function automatic out_t predict_result(in_t beat);
    out_t res;
    res = '0;
    case (beat.cmd)
      CMD_TICK: begin
        count_down(1'b0);
        count_down(1'b1);
      end
      CMD_READ: begin
        res.read_data = shadow_regs[beat.reg_index];
        // Reading the flag byte clears it; the line drops only if a flag was up.
        if (beat.reg_index == REG_ICR) begin
          if (res.read_data[ICR_IR]) irq_out = 1'b0;
          shadow_regs[REG_ICR] = 8'h00;
        end
      end
      CMD_WRITE: write_register(beat.reg_index, beat.write_data);
      default: ;
    endcase
    res.irq_line = irq_out;
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!idling_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void report_mismatch(string text);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("Mismatch at cycle %0d: %s", cycle_count, text);
  endfunction

  initial begin : result_stall
    int span;
    forever begin
      out_stall <= 1'b0;
      span = 1 + pick_gap();
      repeat (span) @(posedge clk);
      span = pick_gap();
      if (span != 0) begin
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat read_data %02h irq_line %0b",
                                  out_data.read_data, out_data.irq_line));
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data !== want.read_data || out_data.irq_line !== want.irq_line)
          report_mismatch($sformatf("read_data expected %02h got %02h, irq_line expected %0b got %0b",
                                    want.read_data, out_data.read_data,
                                    want.irq_line, out_data.irq_line));
      end
    end
  end

  // Valid is left high after a beat is taken, so that a following beat with
  // no gap keeps it high without a second assignment in the same step.
  task automatic send_beat(logic [1:0] op, logic [3:0] idx, logic [7:0] value);
    in_t beat;
    int  gap;
    beat.cmd        = cmd_t'(op);
    beat.reg_index  = idx;
    beat.write_data = value;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_result(beat));
    sent_count++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Both counters are zero after reset, so running timers must stay there.
  task automatic test_counter_at_zero();
    send_beat(CMD_WRITE, REG_CRA, 8'h01);
    send_beat(CMD_WRITE, REG_CRB, 8'h01);
    send_beat(CMD_TICK, 4'd0, 8'h00);
    send_beat(CMD_READ, REG_TA_LO, 8'h00);
    send_beat(CMD_READ, REG_TB_LO, 8'h00);
  endtask

  task automatic test_register_storage();
    send_beat(CMD_WRITE, 4'd0, 8'hff);
    send_beat(CMD_WRITE, 4'd12, 8'h00);
    send_beat(CMD_UNUSED, 4'd0, 8'h5a);
    send_beat(CMD_READ, 4'd0, 8'h00);
    send_beat(CMD_READ, 4'd12, 8'hff);
  endtask

  task automatic test_timer_a_one_shot();
    send_beat(CMD_WRITE, REG_ICR, 8'h81);
    send_beat(CMD_WRITE, REG_TA_LO, 8'h02);
    // Timer A is running, so the high byte goes to the latch only.
    send_beat(CMD_WRITE, REG_TA_HI, 8'h00);
    send_beat(CMD_WRITE, REG_CRA, 8'h19);
    send_beat(CMD_TICK, 4'd0, 8'h00);
    send_beat(CMD_TICK, 4'd0, 8'h00);
    send_beat(CMD_READ, REG_ICR, 8'h00);
  endtask

  task automatic test_cascade_silent_underflow();
    send_beat(CMD_WRITE, REG_TB_LO, 8'h03);
    send_beat(CMD_WRITE, REG_TB_HI, 8'h00);
    send_beat(CMD_WRITE, REG_CRB, 8'h30);
    send_beat(CMD_WRITE, REG_ICR, 8'h01);
    send_beat(CMD_WRITE, REG_CRA, 8'h01);
    send_beat(CMD_TICK, 4'd0, 8'h00);
    send_beat(CMD_TICK, 4'd0, 8'h00);
    send_beat(CMD_READ, REG_TB_LO, 8'h00);
  endtask

  // Mostly timers programmed with short reloads followed by a burst of ticks
  // and reads, so that underflows, one-shot stops and cascades happen often.
  task automatic test_random_traffic();
    int         start_count;
    int         run_len;
    int         roll;
    logic [7:0] ctrl;
    logic [7:0] mask_byte;
    start_count = sent_count;
    while (sent_count - start_count < RANDOM_ITEMS) begin
      idling_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 7) begin
        mask_byte = 8'($urandom_range(0, 31));
        mask_byte[ICR_SETCLR] = ($urandom_range(0, 3) != 0);
        send_beat(CMD_WRITE, REG_ICR, mask_byte);
        for (int t = 0; t < 2; t++) begin
          ctrl = 8'($urandom_range(0, 255));
          ctrl[CR_START] = ($urandom_range(0, 4) != 0);
          ctrl[CR_LOAD]  = ($urandom_range(0, 3) != 0);
          send_beat(CMD_WRITE, t ? REG_TB_LO : REG_TA_LO, 8'($urandom_range(0, 7)));
          send_beat(CMD_WRITE, t ? REG_TB_HI : REG_TA_HI,
                    ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
          send_beat(CMD_WRITE, t ? REG_CRB : REG_CRA, ctrl);
        end
        run_len = $urandom_range(10, 40);
        repeat (run_len) begin
          roll = $urandom_range(0, 99);
          if (roll < 70) send_beat(CMD_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
          else if (roll < 80) send_beat(CMD_READ, REG_ICR, 8'($urandom_range(0, 255)));
          else if (roll < 88) send_beat(CMD_READ, 4'($urandom_range(0, 15)), 8'h00);
          else if (roll < 96) send_beat(CMD_WRITE, 4'($urandom_range(0, 15)),
                                        8'($urandom_range(0, 255)));
          else send_beat(CMD_WRITE, REG_ICR, 8'($urandom_range(0, 255)));
        end
      end else begin
        run_len = $urandom_range(10, 30);
        repeat (run_len)
          send_beat(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                    8'($urandom_range(0, 255)));
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_counter_at_zero();
    test_register_storage();
    test_timer_a_one_shot();
    test_cascade_silent_underflow();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
